// ----- rtl/life_generation_stencil_assert.svh -----
// Assertion macros shared by the RTL. They expect clk and rst_n in scope.
`ifndef LIFE_GENERATION_STENCIL_ASSERT_SVH
`define LIFE_GENERATION_STENCIL_ASSERT_SVH

`ifndef SYNTHESIS
`define LGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LGS_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define LGS_ASSERT(label, prop, msg)
`define LGS_ASSERT_NEXT(label, cause, effect, msg)
`endif

`endif

// ----- rtl/lgs_pkg.sv -----
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COL_H     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd700;
  localparam logic [DIM_W-1:0] ROW_SAT   = 11'd2047;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // One column of the 3x3 window; bit 0 is the top row.
  typedef logic [COL_H-1:0] column_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- rtl/life_generation_stencil.sv -----
`timescale 1ns / 1ps

// One generation of Life (birth on 3, survival on 2 or 3) over a grid of
// grid_width by grid_height cells that stream in raster order, followed by
// grid_width+1 padding transactions. The block takes one transaction per
// cycle. Each transaction is read from the line buffer (one read and one write
// port, MAX_WIDTH x 2 bits) in the cycle it is accepted and is registered in
// the stage. When it leaves the stage it joins the three-column window, and the
// same edge loads its result, if any, into the output register. A result that
// waits for out_ready holds the next transaction in the stage, and that stops
// the input until the result is taken. Cells outside the grid count as dead.
// The line buffer needs no clearing after reset. Configuration writes are taken
// at any time but should be made only while no transaction is in flight.
`include "life_generation_stencil_assert.svh"

module life_generation_stencil import lgs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_alive,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_alive_next,
  output logic                 out_last_cell,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int HW = (HB > DIM_W) ? HB : DIM_W;
  localparam int HX = HW + 1;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          alive;
    logic [2:0]    row_ok;
    logic          c0;
    logic          c1;
    logic          endout;
    logic          last;
    logic          out;
  } stage_t;

  logic [DIM_W-1:0] grid_width_r;
  logic [DIM_W-1:0] grid_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range sizes: zero acts as one, anything above the maximum as the maximum.
  logic [WW-1:0] gw, w_eff;
  logic [HW-1:0] gh, h_eff;

  assign gw    = WW'(grid_width_r);
  assign w_eff = (gw == '0) ? WW'(1) : ((gw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : gw);
  assign gh    = HW'(grid_height_r);
  assign h_eff = (gh == '0) ? HW'(1) : ((gh > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : gh);

  logic             in_fire, b_fire, produce;
  logic             st_valid_r;
  stage_t           st_r, st_nxt;
  logic [AW-1:0]    col_r, col_nxt, col_start, col_cur;
  logic [DIM_W-1:0] row_r, row_nxt, row_cur;
  logic             row_end;
  logic [HX-1:0]    rx, hx;

  assign in_fire = in_valid && in_ready;
  assign b_fire  = st_valid_r && (!out_valid || out_ready);
  assign in_ready = !st_valid_r || b_fire;

  // Position of the incoming cell. A column beyond a shrunken width starts the row over.
  assign col_start = in_frame_start ? '0 : col_r;
  assign row_cur   = in_frame_start ? '0 : row_r;
  assign col_cur   = (WW'(col_start) >= w_eff) ? '0 : col_start;
  assign row_end   = (WW'(col_cur) + WW'(1)) >= w_eff;
  assign col_nxt   = row_end ? '0 : col_cur + AW'(1);
  assign row_nxt   = (row_end && (row_cur != ROW_SAT)) ? row_cur + DIM_W'(1) : row_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign rx = HX'(row_cur);
  assign hx = HX'(h_eff);

  always_comb begin
    st_nxt.addr      = col_cur;
    st_nxt.alive     = in_alive;
    st_nxt.row_ok[2] = rx < hx;
    st_nxt.row_ok[1] = (rx >= HX'(1)) && (rx < hx + HX'(1));
    st_nxt.row_ok[0] = (rx >= HX'(2)) && (rx < hx + HX'(2));
    st_nxt.c0        = (col_cur == '0);
    st_nxt.c1        = (col_cur == AW'(1));
    st_nxt.endout    = st_nxt.c0 && st_nxt.row_ok[0];
    st_nxt.last      = (rx == hx + HX'(1));
    st_nxt.out       = !st_nxt.c0 && st_nxt.row_ok[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      st_r       <= '0;
    end else if (in_fire) begin
      st_valid_r <= 1'b1;
      st_r       <= st_nxt;
    end else if (b_fire) begin
      st_valid_r <= 1'b0;
    end
  end

  logic [1:0] line_rd, line_wr, line_cur, byp_data_r;
  logic       byp_r;

  lgs_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_lines (
    .clk     (clk),
    .wr_en   (b_fire),
    .wr_addr (st_r.addr),
    .wr_data (line_wr),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_data (line_rd)
  );

  // A read in the same cycle as a write to the same column gets the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (in_fire) begin
      byp_r <= b_fire && (st_r.addr == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_data_r <= line_wr;
    end
  end

  column_t col_new;

  assign line_cur = byp_r ? byp_data_r : line_rd;
  assign line_wr  = {line_cur[0], st_r.alive};
  assign col_new  = {st_r.alive & st_r.row_ok[2],
                     line_cur[0] & st_r.row_ok[1],
                     line_cur[1] & st_r.row_ok[0]};

  // Window: cell 2 takes the new column, cells 1 and 0 hold the older ones.
  cell_ctrl_t ctrl [3];
  column_t    cell_d [3];
  column_t    cell_q [3];
  column_t    cell_qn [3];

  always_comb begin
    cell_d[2]      = col_new;
    cell_d[1]      = cell_q[2];
    cell_d[0]      = cell_q[1];
    ctrl[2].shift  = b_fire;
    ctrl[2].clear  = 1'b0;
    ctrl[1].shift  = b_fire;
    ctrl[1].clear  = st_r.c0;
    ctrl[0].shift  = b_fire;
    ctrl[0].clear  = st_r.c0 || st_r.c1;
  end

  for (genvar g = 0; g < 3; g++) begin : g_window
    lgs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl[g]),
      .col_in  (cell_d[g]),
      .col_q   (cell_q[g]),
      .col_nxt (cell_qn[g])
    );
  end

  logic alive_mid, alive_edge;

  lgs_rule u_rule_mid (
    .col_left   (cell_qn[0]),
    .col_mid    (cell_qn[1]),
    .col_right  (cell_qn[2]),
    .alive_next (alive_mid)
  );

  // Last cell of the row two up: its right neighbor lies outside the grid.
  lgs_rule u_rule_edge (
    .col_left   (cell_q[1]),
    .col_mid    (cell_q[2]),
    .col_right  ('0),
    .alive_next (alive_edge)
  );

  assign produce = st_r.endout || st_r.out;

  logic out_valid_r, out_alive_next_r, out_last_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && produce) begin
      out_alive_next_r <= st_r.endout ? alive_edge : alive_mid;
      out_last_cell_r  <= st_r.endout && st_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alive_next = out_alive_next_r;
  assign out_last_cell  = out_last_cell_r;

  `LGS_ASSERT(a_one_result, st_valid_r |-> !(st_r.endout && st_r.out), "two results for one cell")
  `LGS_ASSERT_NEXT(a_result_lands, b_fire && produce, out_valid_r, "result was not registered")
  `LGS_ASSERT_NEXT(a_stage_holds, st_valid_r && !b_fire, st_valid_r && $stable(st_r), "stage lost")

endmodule

// ----- rtl/lgs_line_buffer.sv -----
`timescale 1ns / 1ps

module lgs_line_buffer import lgs_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  // Bit 1 holds the row two above the incoming one, bit 0 the row just above.
  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lgs_cell.sv -----
`timescale 1ns / 1ps

module lgs_cell import lgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  column_t    col_in,
  output column_t    col_q,
  output column_t    col_nxt
);

  column_t col_r;

  assign col_nxt = ctrl.clear ? '0 : col_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctrl.shift) begin
      col_r <= col_nxt;
    end
  end

  assign col_q = col_r;

endmodule

// ----- rtl/lgs_rule.sv -----
`timescale 1ns / 1ps

module lgs_rule import lgs_pkg::*; (
  input  column_t col_left,
  input  column_t col_mid,
  input  column_t col_right,
  output logic    alive_next
);

  logic [8:0] win;
  logic [3:0] neighbors;

  assign win = {col_right, col_mid, col_left};

  // Bit 4 is the cell itself; the other eight are its neighbors.
  always_comb begin
    neighbors = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        neighbors = neighbors + {3'b000, win[i]};
      end
    end
  end

  assign alive_next = (neighbors == BIRTH_COUNT) ||
                      (win[4] && (neighbors == SURVIVE_COUNT));

endmodule
